// ===== hw/rtl/mpp_pkg.sv =====
// Shared types and constants for the middle-pivot partition block.
// No dependencies; imported by mpp_store, mpp_seq and the top level.
`timescale 1ns / 1ps

package mpp_pkg;

  localparam int DEF_MAX_ELEMS = 32;
  localparam int DATA_W        = 32;
  localparam int KIND_W        = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_PIVOT = 2'd0,
    KIND_LOWER = 2'd1,
    KIND_UPPER = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    S_LOAD,
    S_PIV_RD,
    S_PIV_CAP,
    S_OUTER,
    S_SCAN_L,
    S_SCAN_R,
    S_SWAP,
    S_REP_PIV,
    S_REP_RD,
    S_REP_WR
  } state_t;

  // memory port strobes
  typedef struct packed {
    logic we;
    logic re;
  } mem_ctl_t;

endpackage

// ===== hw/rtl/mpp_store.sv =====
// Element store: one write port, one read port, registered read data.
// Depends on mpp_pkg.
`timescale 1ns / 1ps

module mpp_store
  import mpp_pkg::*;
#(
  parameter int MAX_ELEMS = DEF_MAX_ELEMS,
  localparam int AW = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1
) (
  input  logic                     clk,
  input  mem_ctl_t                 mctl,
  input  logic [AW-1:0]            waddr,
  input  logic signed [DATA_W-1:0] wdata,
  input  logic [AW-1:0]            raddr,
  output logic signed [DATA_W-1:0] rdata
);

  logic signed [DATA_W-1:0] mem [MAX_ELEMS];

  always_ff @(posedge clk) begin
    if (mctl.we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (mctl.re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/mpp_seq.sv =====
// Load / partition / report sequencer with the result output register.
// Depends on mpp_pkg; drives the mpp_store ports.
`timescale 1ns / 1ps

module mpp_seq
  import mpp_pkg::*;
#(
  parameter int MAX_ELEMS = DEF_MAX_ELEMS,
  localparam int AW = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1,
  localparam int CW = $clog2(MAX_ELEMS + 1)
) (
  input  logic                     clk,
  input  logic                     rst,
  // item channel
  input  logic                     item_valid,
  output logic                     item_stall,
  input  logic signed [DATA_W-1:0] value,
  input  logic                     final_req,
  // result channel
  output logic                     result_valid,
  input  logic                     result_stall,
  output logic [KIND_W-1:0]        kind,
  output logic signed [DATA_W-1:0] element,
  output logic                     end_of_run,
  // store port
  output mem_ctl_t                 mctl,
  output logic [AW-1:0]            waddr,
  output logic signed [DATA_W-1:0] wdata,
  output logic [AW-1:0]            raddr,
  input  logic signed [DATA_W-1:0] rdata
);

  state_t state, state_next;

  logic [CW-1:0]            count;   // elements loaded so far
  logic [CW-1:0]            n;       // set size of the current run
  logic [CW-1:0]            lc;      // left cursor
  logic [CW-1:0]            rc1;     // right cursor plus one
  logic [CW-1:0]            idx;     // report index
  logic                     upper_phase;
  logic signed [DATA_W-1:0] pivot;
  logic signed [DATA_W-1:0] a_val;   // element held at the left cursor

  logic item_acc;
  logic last_item;
  logic adv_l;
  logic adv_r;
  logic do_swap;
  logic out_free;
  logic load_out;
  logic out_end;
  kind_t out_kind;
  logic signed [DATA_W-1:0] out_elem;

  assign item_stall = (state != S_LOAD);
  assign item_acc   = item_valid && !item_stall;
  assign last_item  = final_req || (count == CW'(MAX_ELEMS - 1));
  assign out_free   = !result_valid || !result_stall;

  assign adv_l   = (lc < n - 1'b1) && (rdata < pivot);
  assign adv_r   = (rc1 > CW'(1)) && (rdata > pivot);
  assign do_swap = (lc < rc1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mctl       = '0;
    waddr      = count[AW-1:0];
    wdata      = value;
    raddr      = lc[AW-1:0];
    load_out   = 1'b0;
    out_kind   = KIND_PIVOT;
    out_elem   = pivot;
    out_end    = 1'b0;
    unique case (state)
      S_LOAD: begin
        if (item_acc) begin
          mctl.we = 1'b1;
          if (last_item) state_next = S_PIV_RD;
        end
      end
      S_PIV_RD: begin
        mctl.re    = 1'b1;
        raddr      = AW'(n >> 1);
        state_next = S_PIV_CAP;
      end
      S_PIV_CAP: begin
        state_next = S_OUTER;
      end
      S_OUTER: begin
        if (lc < rc1) begin
          mctl.re    = 1'b1;
          raddr      = lc[AW-1:0];
          state_next = S_SCAN_L;
        end else begin
          state_next = S_REP_PIV;
        end
      end
      S_SCAN_L: begin
        mctl.re = 1'b1;
        if (adv_l) begin
          raddr = AW'(lc + 1'b1);
        end else begin
          raddr      = AW'(rc1 - 1'b1);
          state_next = S_SCAN_R;
        end
      end
      S_SCAN_R: begin
        if (adv_r) begin
          mctl.re = 1'b1;
          raddr   = AW'(rc1 - CW'(2));
        end else if (do_swap) begin
          mctl.we    = 1'b1;
          waddr      = lc[AW-1:0];
          wdata      = rdata;
          state_next = S_SWAP;
        end else begin
          state_next = S_OUTER;
        end
      end
      S_SWAP: begin
        mctl.we    = 1'b1;
        waddr      = AW'(rc1 - 1'b1);
        wdata      = a_val;
        state_next = S_OUTER;
      end
      S_REP_PIV: begin
        if (out_free) begin
          load_out   = 1'b1;
          out_kind   = KIND_PIVOT;
          out_elem   = pivot;
          out_end    = (lc == '0) && (rc1 == n);
          state_next = S_REP_RD;
        end
      end
      S_REP_RD: begin
        raddr = idx[AW-1:0];
        if (!upper_phase) begin
          if (idx < lc) begin
            mctl.re    = 1'b1;
            state_next = S_REP_WR;
          end
        end else if (idx < n) begin
          mctl.re    = 1'b1;
          state_next = S_REP_WR;
        end else begin
          state_next = S_LOAD;
        end
      end
      S_REP_WR: begin
        if (out_free) begin
          load_out   = 1'b1;
          out_elem   = rdata;
          out_kind   = upper_phase ? KIND_UPPER : KIND_LOWER;
          out_end    = upper_phase ? (idx == n - 1'b1)
                                   : ((CW'(idx + 1'b1) == lc) && (rc1 == n));
          state_next = S_REP_RD;
        end
      end
      default: state_next = S_LOAD;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      case (state)
        S_LOAD: begin
          if (item_acc) begin
            if (last_item) begin
              count <= '0;
              n     <= CW'(count + 1'b1);
            end else begin
              count <= CW'(count + 1'b1);
            end
          end
        end
        S_PIV_CAP: begin
          pivot <= rdata;
          lc    <= '0;
          rc1   <= n;
        end
        S_SCAN_L: begin
          if (adv_l) lc <= CW'(lc + 1'b1);
          else       a_val <= rdata;
        end
        S_SCAN_R: begin
          if (adv_r) rc1 <= CW'(rc1 - 1'b1);
        end
        S_SWAP: begin
          lc  <= CW'(lc + 1'b1);
          rc1 <= CW'(rc1 - 1'b1);
        end
        S_REP_PIV: begin
          idx         <= '0;
          upper_phase <= 1'b0;
        end
        S_REP_RD: begin
          if (!upper_phase && !(idx < lc)) begin
            upper_phase <= 1'b1;
            idx         <= rc1;
          end
        end
        S_REP_WR: begin
          if (out_free) idx <= CW'(idx + 1'b1);
        end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_out) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      kind       <= out_kind;
      element    <= out_elem;
      end_of_run <= out_end;
    end
  end

  // a pending result is never overwritten
  assert property (@(posedge clk) disable iff (rst) load_out |-> out_free)
    else $error("result register overwritten while stalled");

  // loading never runs past the store
  assert property (@(posedge clk) disable iff (rst) item_acc |-> (count < CW'(MAX_ELEMS)))
    else $error("load beyond store capacity");

  // no read and write of the same entry in one cycle
  assert property (@(posedge clk) disable iff (rst)
    (mctl.we && mctl.re) |-> (waddr != raddr))
    else $error("store read/write collision");

  // cursors stay within the set while reporting
  assert property (@(posedge clk) disable iff (rst)
    (state == S_REP_RD) |-> ((lc <= n) && (rc1 <= n)))
    else $error("cursor out of range");

endmodule

// ===== hw/rtl/middle_pivot_partition_unit.sv =====
// Top level of the middle-pivot partition block.
// Depends on mpp_pkg, mpp_store and mpp_seq.
`timescale 1ns / 1ps

// Usage:
//   Item channel (item_valid / item_stall, value, final_req): one signed
//   element per transaction, taken one per cycle while loading. The element
//   with final_req set, or the one that fills the store (MAX_ELEMS), closes
//   the set and starts the run; item_stall stays high until the report of
//   that set has been handed to the result register.
//   Result channel (result_valid / result_stall, kind, element, end_of_run):
//   the pivot (element at index n/2) first, then the lower group, then the
//   upper group; end_of_run marks the final transaction of the run.
// Flow, for a set of n elements:
//   load       one element per cycle while item_stall is low
//   partition  pivot read and capture, then passes of a left scan, a
//              right scan and, if the cursors have not crossed, a swap
//   report     the pivot, then each group element (read, then result
//              register); at most n + 2 results; a stalled result
//              simply holds the sequencer.
//   The last result may still wait in the output register while the next
//   set loads.
// Reset (rst, synchronous): empties the store count and the result register;
// store contents are not cleared and need not be.

module middle_pivot_partition_unit
  import mpp_pkg::*;
#(
  parameter int MAX_ELEMS = DEF_MAX_ELEMS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     item_valid,
  output logic                     item_stall,
  input  logic signed [DATA_W-1:0] value,
  input  logic                     final_req,
  output logic                     result_valid,
  input  logic                     result_stall,
  output logic [KIND_W-1:0]        kind,
  output logic signed [DATA_W-1:0] element,
  output logic                     end_of_run
);

  localparam int AW = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1;

  mem_ctl_t                 mctl;
  logic [AW-1:0]            waddr;
  logic [AW-1:0]            raddr;
  logic signed [DATA_W-1:0] wdata;
  logic signed [DATA_W-1:0] rdata;

  // sequencer: load, Hoare walk with swaps, and the report
  mpp_seq #(
    .MAX_ELEMS(MAX_ELEMS)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .value        (value),
    .final_req    (final_req),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .kind         (kind),
    .element      (element),
    .end_of_run   (end_of_run),
    .mctl         (mctl),
    .waddr        (waddr),
    .wdata        (wdata),
    .raddr        (raddr),
    .rdata        (rdata)
  );

  // element store
  mpp_store #(
    .MAX_ELEMS(MAX_ELEMS)
  ) u_store (
    .clk   (clk),
    .mctl  (mctl),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

endmodule

// ===== tb/partition_check_pkg.sv =====
// Scoreboard for the middle-pivot partition unit: predicts the report of each set.
// Depends on mpp_pkg for the kind codes, widths and store depth.
`timescale 1ns / 1ps

package partition_check_pkg;
  import mpp_pkg::*;

  localparam int STORE_DEPTH = DEF_MAX_ELEMS;

  typedef struct {
    kind_t                     kind;
    logic signed [DATA_W-1:0]  element;
    bit                        last;
  } report_t;

  class partition_scoreboard;
    logic signed [DATA_W-1:0] held[STORE_DEPTH];
    int                       held_count;
    report_t                  report_q[$];
    int                       errors;
    int                       sets_closed;
    int                       results_checked;
    int                       largest_set;

    function new();
      held_count      = 0;
      errors          = 0;
      sets_closed     = 0;
      results_checked = 0;
      largest_set     = 0;
    endfunction

    function int pending();
      return report_q.size();
    endfunction

    // Hoare walk around the middle element, then queue the report.
    function void partition_set();
      int                       n;
      int                       lc;
      int                       rc;
      logic signed [DATA_W-1:0] piv;
      logic signed [DATA_W-1:0] tmp;
      report_t                  r;
      n          = held_count;
      held_count = 0;
      lc         = 0;
      rc         = n - 1;
      piv        = held[n / 2];
      while (lc <= rc) begin
        while (lc < n - 1 && held[lc] < piv) lc++;
        while (rc > 0 && held[rc] > piv) rc--;
        if (lc <= rc) begin
          tmp      = held[lc];
          held[lc] = held[rc];
          held[rc] = tmp;
          lc++;
          rc--;
        end
      end
      r.last    = 1'b0;
      r.kind    = KIND_PIVOT;
      r.element = piv;
      report_q.push_back(r);
      for (int i = 0; i < lc && i < n; i++) begin
        r.kind    = KIND_LOWER;
        r.element = held[i];
        report_q.push_back(r);
      end
      for (int i = (rc + 1 < 0) ? 0 : rc + 1; i < n; i++) begin
        r.kind    = KIND_UPPER;
        r.element = held[i];
        report_q.push_back(r);
      end
      report_q[report_q.size() - 1].last = 1'b1;
      sets_closed++;
      if (n > largest_set) largest_set = n;
    endfunction

    function void note_item(logic signed [DATA_W-1:0] v, bit last_req);
      held[held_count] = v;
      held_count++;
      if (last_req || held_count >= STORE_DEPTH) partition_set();
    endfunction

    function void check_result(logic [KIND_W-1:0] k, logic signed [DATA_W-1:0] e,
                               logic eor);
      report_t want;
      if (report_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual kind %0d element %0d",
                 $time, k, e);
        return;
      end
      want = report_q.pop_front();
      results_checked++;
      if (k !== want.kind) begin
        errors++;
        $display("%0t: kind mismatch, expected %0d actual %0d", $time, want.kind, k);
      end
      if (e !== want.element) begin
        errors++;
        $display("%0t: element mismatch, expected %0d actual %0d", $time,
                 want.element, e);
      end
      if (eor !== want.last) begin
        errors++;
        $display("%0t: end_of_run mismatch, expected %0d actual %0d", $time,
                 want.last, eor);
      end
    endfunction
  endclass

endpackage

// ===== tb/tb_top.sv =====
// Top-level testbench for middle_pivot_partition_unit: drives element sets,
// checks every report transaction. Depends on mpp_pkg and partition_check_pkg.
`timescale 1ns / 1ps

module tb_top;
  import mpp_pkg::*;
  import partition_check_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 420;
  localparam int HOLD_CYCLES  = 400;
  localparam int TAIL_CYCLES  = 200;

  // value mixes for random sets
  localparam int MIX_WIDE    = 0;
  localparam int MIX_NARROW  = 1;
  localparam int MIX_EXTREME = 2;

  logic                     clk;
  logic                     rst          = 1'b1;
  logic                     item_valid   = 1'b0;
  logic                     item_stall;
  logic signed [DATA_W-1:0] value        = '0;
  logic                     final_req    = 1'b0;
  logic                     result_valid;
  logic                     result_stall = 1'b0;
  logic [KIND_W-1:0]        kind;
  logic signed [DATA_W-1:0] element;
  logic                     end_of_run;

  partition_scoreboard sb = new();

  int  send_idle_pct  = 0;   // chance per cycle that the sender holds back
  int  recv_stall_pct = 0;   // chance per cycle that the receiver stalls
  bit  hold_request   = 1'b0;
  bit  hold_taken     = 1'b0;
  int  hold_left      = 0;
  int  cycle_count    = 0;
  int  items_sent     = 0;

  middle_pivot_partition_unit dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .value        (value),
    .final_req    (final_req),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .kind         (kind),
    .element      (element),
    .end_of_run   (end_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Time %0t: cycle limit reached, %0d results still due", $time,
               sb.pending());
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver side. Random stall per cycle, plus one long hold-off counted
  // here so the block backs up into its item channel.
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else if (hold_request && !hold_taken) begin
      hold_taken   = 1'b1;
      hold_left    = HOLD_CYCLES - 1;
      result_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Result monitor. Outputs and stall are settled at the falling edge, so a
  // transaction seen here is the one taken at the next rising edge.
  always @(negedge clk) begin
    if (!rst && result_valid && !result_stall)
      sb.check_result(kind, element, end_of_run);
  end

  // One item transaction. Starts and ends on a rising edge. Stall is sampled
  // at the falling edge to stay clear of the edge itself.
  task automatic send_item(input logic signed [DATA_W-1:0] v, input bit last_req);
    bit taken;
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    value      <= v;
    final_req  <= last_req;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !item_stall;
      @(posedge clk);
    end
    sb.note_item(v, last_req);
    items_sent++;
  endtask

  // A set closes with final_req on its last element; a full store closes
  // by itself, so there final_req may be either value.
  task automatic send_set(input logic signed [DATA_W-1:0] vals[$]);
    int n;
    bit last_req;
    n = vals.size();
    for (int i = 0; i < n; i++) begin
      if (i < n - 1)
        last_req = 1'b0;
      else if (n >= STORE_DEPTH)
        last_req = 1'($urandom_range(1));
      else
        last_req = 1'b1;
      send_item(vals[i], last_req);
    end
  endtask

  // Sender goes idle, then waits on the clock until all is reported.
  task automatic wait_drained();
    item_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value(input int mix);
    logic signed [DATA_W-1:0] v;
    case (mix)
      MIX_NARROW: begin
        v = $signed($urandom_range(8)) - 4;
      end
      MIX_EXTREME: begin
        case ($urandom_range(5))
          0: v = 32'sh8000_0000;
          1: v = 32'sh7fff_ffff;
          2: v = '0;
          3: v = -1;
          4: v = 1;
          default: v = $urandom;
        endcase
      end
      default: begin
        v = $urandom;
      end
    endcase
    return v;
  endfunction

  // Mostly short sets, some medium, a few that fill the store.
  task automatic send_random_set();
    logic signed [DATA_W-1:0] vals[$];
    int n;
    int mix;
    int r;
    r = $urandom_range(99);
    if (r < 70)
      n = $urandom_range(8, 1);
    else if (r < 92)
      n = $urandom_range(20, 9);
    else
      n = STORE_DEPTH;
    mix = $urandom_range(MIX_EXTREME);
    for (int i = 0; i < n; i++) vals.push_back(pick_value(mix));
    send_set(vals);
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input int quota);
    int start;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    start = items_sent;
    while (items_sent - start < quota) send_random_set();
    // sender pauses until the whole backlog has been reported
    wait_drained();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed sets, no idling: single elements at both extremes, a pair,
    // all-equal, reverse and forward order, mixed extremes.
    send_set('{32'sh8000_0000});
    send_set('{32'sh7fff_ffff});
    send_set('{32'sd0, -32'sd1});
    send_set('{32'sd3, 32'sd3, 32'sd3});
    send_set('{32'sd5, 32'sd4, 32'sd3, 32'sd2, 32'sd1});
    send_set('{32'sh8000_0000, 32'sh7fff_ffff, 32'sd0, -32'sd1, 32'sd1});
    send_set('{32'sd1, 32'sd2, 32'sd3, 32'sd4, 32'sd5, 32'sd6});
    wait_drained();

    // Random sets across the idling mixes.
    run_phase(0, 0, RANDOM_ITEMS / 4);
    run_phase(65, 0, RANDOM_ITEMS / 4);
    // long receiver hold-off while the sender keeps offering
    hold_request = 1'b1;
    run_phase(0, 65, RANDOM_ITEMS / 4);
    run_phase(20, 20, RANDOM_ITEMS / 4);

    // Quiet tail so a stray extra transaction would still be caught.
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d sets (%0d elements, largest %0d), %0d report transactions",
             sb.sets_closed, items_sent, sb.largest_set, sb.results_checked);
    $display("Idling mixes: none, sender 65%%, receiver 65%% with long hold, both 20%%");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Errors: %0d, results still due: %0d", sb.errors, sb.pending());
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
